@@ src/alil_pkg.sv @@
`timescale 1ns / 1ps
// alil_pkg: shared types and codes for the arc length inverse lookup
// used by alil_ctrl, alil_dp and arc_length_inverse_lookup_top

package alil_pkg;

  localparam int CFG_WIDTH   = 9;
  localparam int INDEX_WIDTH = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_CHECK,
    ST_FETCH_LO,
    ST_CAPT_LO,
    ST_PREP,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH,
    ST_PUBLISH
  } alil_state_t;

  typedef struct packed {
    logic accept;
    logic srch_rd;
    logic srch_upd;
    logic check;
    logic hi_rd;
    logic lo_rd;
    logic hi_cap;
    logic lo_cap;
    logic prep;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
    logic publish;
  } alil_ctl_t;

  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic first_zero;
    logic first_ge_n;
    logic range_pos;
    logic div_done;
    logic out_free;
  } alil_sts_t;

endpackage

@@ src/alil_ctrl.sv @@
`timescale 1ns / 1ps
// alil_ctrl: sequencing state machine for the lookup
// depends on alil_pkg; drives alil_dp through alil_ctl_t

module alil_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  alil_pkg::alil_sts_t sts,
  output alil_pkg::alil_ctl_t ctl
);

  alil_pkg::alil_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alil_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    unique case (state)
      alil_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = sts.is_query ? alil_pkg::ST_SRCH_ADDR : alil_pkg::ST_PUBLISH;
        end
      end
      alil_pkg::ST_SRCH_ADDR: begin
        if (sts.count_zero) begin
          state_next = alil_pkg::ST_CHECK;
        end else begin
          ctl.srch_rd = 1'b1;
          state_next  = alil_pkg::ST_SRCH_CMP;
        end
      end
      alil_pkg::ST_SRCH_CMP: begin
        ctl.srch_upd = 1'b1;
        state_next   = alil_pkg::ST_SRCH_ADDR;
      end
      alil_pkg::ST_CHECK: begin
        if (sts.first_zero || sts.first_ge_n) begin
          ctl.check  = 1'b1;
          state_next = alil_pkg::ST_PUBLISH;
        end else begin
          ctl.hi_rd  = 1'b1;
          state_next = alil_pkg::ST_FETCH_LO;
        end
      end
      alil_pkg::ST_FETCH_LO: begin
        ctl.lo_rd  = 1'b1;
        ctl.hi_cap = 1'b1;
        state_next = alil_pkg::ST_CAPT_LO;
      end
      alil_pkg::ST_CAPT_LO: begin
        ctl.lo_cap = 1'b1;
        state_next = alil_pkg::ST_PREP;
      end
      alil_pkg::ST_PREP: begin
        ctl.prep   = 1'b1;
        state_next = alil_pkg::ST_MUL;
      end
      alil_pkg::ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = sts.range_pos ? alil_pkg::ST_DIV_INIT : alil_pkg::ST_PUBLISH;
      end
      alil_pkg::ST_DIV_INIT: begin
        ctl.div_init = 1'b1;
        state_next   = alil_pkg::ST_DIV;
      end
      alil_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = alil_pkg::ST_FINISH;
        end
      end
      alil_pkg::ST_FINISH: begin
        ctl.finish = 1'b1;
        state_next = alil_pkg::ST_PUBLISH;
      end
      alil_pkg::ST_PUBLISH: begin
        if (sts.out_free) begin
          ctl.publish = 1'b1;
          state_next  = alil_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = alil_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/alil_dp.sv @@
`timescale 1ns / 1ps
// alil_dp: table memory, search registers, interpolation and serial divider
// depends on alil_pkg; controlled by alil_ctrl

module alil_dp #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  alil_pkg::alil_ctl_t                 ctl,
  output alil_pkg::alil_sts_t                 sts,
  input  logic                                cfg_write,
  input  logic [alil_pkg::CFG_WIDTH-1:0]      cfg_data,
  input  logic                                cmd,
  input  logic [alil_pkg::INDEX_WIDTH-1:0]    entry_index,
  input  logic [FRAC_BITS:0]                  entry_param,
  input  logic [FRAC_BITS:0]                  entry_length,
  input  logic signed [FRAC_BITS+1:0]         query_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [FRAC_BITS:0]                  result_param,
  output logic                                is_answer
);

  localparam int VW  = FRAC_BITS + 1;
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int DCW = $clog2(VW + 1);
  localparam logic [VW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VW-1:0] MASK = {VW{1'b1}};

  // table memory, param in the upper half, length in the lower half
  logic [2*VW-1:0] mem [TABLE_DEPTH];
  logic [2*VW-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  logic [31:0]     idx_ext;

  logic [CW-1:0]   n;
  logic [CW-1:0]   first;
  logic [CW-1:0]   count;
  logic [CW-1:0]   step;
  logic [CW-1:0]   probe;
  logic [CW-1:0]   first_m1;
  logic [VW-1:0]   q;
  logic [VW-1:0]   q_clamped;

  logic [VW-1:0]   u_hi;
  logic [VW-1:0]   s_hi;
  logic [VW-1:0]   u_lo;
  logic [VW-1:0]   s_lo;
  logic signed [VW:0] du;
  logic signed [VW:0] dq;
  logic signed [VW:0] rng;
  logic            range_pos;
  logic signed [2*VW+1:0] prod;
  logic [2*VW+1:0] prod_mag;

  logic [VW-1:0]   rem;
  logic [VW:0]     low_bits;
  logic [VW:0]     quot;
  logic            ovf;
  logic            neg;
  logic [DCW-1:0]  div_cnt;
  logic [VW:0]     trial;
  logic signed [VW+2:0] acc;
  logic signed [VW+2:0] quot_s;

  logic [VW-1:0]   res;
  logic            res_ans;

  assign idx_ext = 32'(entry_index);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_en   = ctl.accept && (cmd == alil_pkg::CMD_WRITE) &&
                   (idx_ext < 32'(TABLE_DEPTH));

  assign step     = count >> 1;
  assign probe    = first + step;
  assign first_m1 = first - CW'(1);

  always_comb begin
    priority if (ctl.srch_rd) begin
      rd_addr = probe[AW-1:0];
    end else if (ctl.lo_rd) begin
      rd_addr = first_m1[AW-1:0];
    end else begin
      rd_addr = first[AW-1:0];
    end
  end
  assign rd_en = ctl.srch_rd || ctl.hi_rd || ctl.lo_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {entry_param, entry_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // query clamp to [0, one]
  always_comb begin
    priority if (query_length[VW]) begin
      q_clamped = '0;
    end else if (query_length[VW-1:0] > ONE) begin
      q_clamped = ONE;
    end else begin
      q_clamped = query_length[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cfg_write) begin
      if (32'(cfg_data) > 32'(TABLE_DEPTH)) begin
        n <= CW'(TABLE_DEPTH);
      end else begin
        n <= CW'(cfg_data);
      end
    end
  end

  // search
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      first <= '0;
      count <= n;
      q     <= q_clamped;
    end else if (ctl.srch_upd) begin
      if (rd_data[VW-1:0] < q) begin
        first <= probe + CW'(1);
        count <= count - step - CW'(1);
      end else begin
        count <= step;
      end
    end
  end

  // neighbour fetch and differences
  always_ff @(posedge clk) begin
    if (ctl.hi_cap) begin
      u_hi <= rd_data[2*VW-1:VW];
      s_hi <= rd_data[VW-1:0];
    end
    if (ctl.lo_cap) begin
      u_lo <= rd_data[2*VW-1:VW];
      s_lo <= rd_data[VW-1:0];
    end
    if (ctl.prep) begin
      du        <= $signed({1'b0, u_hi}) - $signed({1'b0, u_lo});
      dq        <= $signed({1'b0, q}) - $signed({1'b0, s_lo});
      rng       <= $signed({1'b0, s_hi}) - $signed({1'b0, s_lo});
      range_pos <= (s_hi > s_lo);
    end
    if (ctl.mul) begin
      prod <= du * dq;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign prod_mag = prod[2*VW+1] ? (2*VW+2)'(-prod) : (2*VW+2)'(prod);
  assign trial    = {rem, low_bits[VW]};

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      neg      <= prod[2*VW+1];
      rem      <= VW'(prod_mag[2*VW-1:VW+1]);
      ovf      <= VW'(prod_mag[2*VW-1:VW+1]) >= rng[VW-1:0];
      low_bits <= prod_mag[VW:0];
      quot     <= '0;
      div_cnt  <= '0;
    end else if (ctl.div_step) begin
      if (trial >= {1'b0, rng[VW-1:0]}) begin
        rem  <= VW'(trial - {1'b0, rng[VW-1:0]});
        quot <= {quot[VW-1:0], 1'b1};
      end else begin
        rem  <= trial[VW-1:0];
        quot <= {quot[VW-1:0], 1'b0};
      end
      low_bits <= {low_bits[VW-1:0], 1'b0};
      div_cnt  <= div_cnt + DCW'(1);
    end
  end

  assign quot_s = $signed({2'b00, quot});
  assign acc    = $signed({3'b000, u_lo}) + (neg ? -quot_s : quot_s);

  // result register
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res     <= '0;
      res_ans <= (cmd == alil_pkg::CMD_QUERY);
    end else if (ctl.check) begin
      res <= (first == '0) ? '0 : ONE;
    end else if (ctl.mul) begin
      res <= u_lo;
    end else if (ctl.finish) begin
      priority if (ovf) begin
        res <= neg ? '0 : MASK;
      end else if (acc < 0) begin
        res <= '0;
      end else if (acc > $signed({3'b000, MASK})) begin
        res <= MASK;
      end else begin
        res <= acc[VW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      result_param <= res;
      is_answer    <= res_ans;
    end
  end

  assign sts.is_query   = (cmd == alil_pkg::CMD_QUERY);
  assign sts.count_zero = (count == '0);
  assign sts.first_zero = (first == '0);
  assign sts.first_ge_n = (first >= n);
  assign sts.range_pos  = range_pos;
  assign sts.div_done   = (div_cnt == DCW'(VW));
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

@@ src/arc_length_inverse_lookup_top.sv @@
`timescale 1ns / 1ps
// arc_length_inverse_lookup_top: table based inverse arc length lookup
// depends on alil_pkg, alil_ctrl and alil_dp
//
// usage:
// input channel (in_valid / in_stall) carries one transaction per item:
//   cmd write stores entry_param / entry_length at entry_index, cmd query
//   maps query_length to a curve parameter. every item gives one result.
// output channel (out_valid / out_stall) returns result_param and is_answer
//   (0 with result 0 for a write, 1 for a query answer).
// cfg_write / cfg_data set the entry count; the user must do so only while the block is idle (not enforced).
// one item at a time. a write goes to the publish state, then into the output register.
// a query that interpolates runs k search halvings, with k up to
//   clog2(entry_count) + 1 (one memory read and one compare each), then the
//   neighbour fetch, the multiply and, if the length range is positive, a
//   serial divider.
// a query below the first entry or past the last ends after the search.
// the next item is accepted the cycle after the result enters the output
//   register, even while that result is still stalled.
// reset clears the entry count and control state; table contents stay
//   undefined until written. a stalled result holds until taken.

module arc_length_inverse_lookup_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [alil_pkg::CFG_WIDTH-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [alil_pkg::INDEX_WIDTH-1:0] entry_index,
  input  logic [FRAC_BITS:0]               entry_param,
  input  logic [FRAC_BITS:0]               entry_length,
  input  logic signed [FRAC_BITS+1:0]      query_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [FRAC_BITS:0]               result_param,
  output logic                             is_answer
);

  alil_pkg::alil_ctl_t ctl;
  alil_pkg::alil_sts_t sts;

  alil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  alil_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_param  (entry_param),
    .entry_length (entry_length),
    .query_length (query_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_param (result_param),
    .is_answer    (is_answer)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_write_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_answer) |-> (result_param == '0))
    else $error("write acknowledge carries a nonzero result");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

endmodule
